### hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared command codes, pipeline record and helpers for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int DATA_WIDTH = 64;
   localparam int HALF_WIDTH = 32;

   typedef enum logic [3:0] {
      CMD_ITOF  = 4'd0,
      CMD_FTOI  = 4'd1,
      CMD_ROUND = 4'd2,
      CMD_ADDFF = 4'd3,
      CMD_SUBFF = 4'd4,
      CMD_MULFF = 4'd5,
      CMD_DIVFF = 4'd6,
      CMD_ADDFI = 4'd7,
      CMD_SUBFI = 4'd8,
      CMD_MULFI = 4'd9,
      CMD_DIVFI = 4'd10
   } cmd_type;

   // One pipeline slot. The multiplier operand fields are reused for partial
   // products; the divider keeps remainder, shifting numerator/quotient and
   // divisor magnitude.
   typedef struct packed {
      logic                    valid;
      logic [3:0]              cmd;
      logic                    dz;
      logic [DATA_WIDTH-1:0]   res;
      logic                    neg;
      logic [DATA_WIDTH-1:0]   rem;
      logic [DATA_WIDTH-1:0]   nq;
      logic [DATA_WIDTH-1:0]   den;
      logic [DATA_WIDTH-1:0]   ma;
      logic [DATA_WIDTH-1:0]   mb;
   } pipe_type;

   // Keep the low word and sign-extend it.
   function automatic logic [DATA_WIDTH-1:0] sext32(input logic [DATA_WIDTH-1:0] x);
      sext32 = {{HALF_WIDTH{x[HALF_WIDTH-1]}}, x[HALF_WIDTH-1:0]};
   endfunction

   // Two's complement magnitude.
   function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] x);
      mag = x[DATA_WIDTH-1] ? (~x + DATA_WIDTH'(1)) : x;
   endfunction

endpackage

### hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Decode stage: evaluate the simple commands and prepare the multiplier and
// divider operands for one transaction.
// ----------------------------------------------------------------------------
module fpa_front #(
   parameter int FRACTION_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [3:0]           command,
   input  logic [63:0]          operand_a,
   input  logic [63:0]          operand_b,
   output fpa_pkg::pipe_type    out_ff
);

   fpa_pkg::pipe_type slot_in;
   logic [63:0]       ai;
   logic [63:0]       bi;
   logic [63:0]       half;
   logic [63:0]       rnd_pos;
   logic [63:0]       rnd_neg;
   logic [63:0]       num;
   logic [63:0]       dvs;

   assign ai   = fpa_pkg::sext32(operand_a);
   assign bi   = fpa_pkg::sext32(operand_b);
   assign half = 64'(1) << (FRACTION_BITS - 1);

   // Round to nearest, halves away from zero
   assign rnd_pos = 64'($signed(operand_a + half) >>> FRACTION_BITS);
   assign rnd_neg = 64'(0) - 64'($signed((64'(0) - operand_a) + half) >>> FRACTION_BITS);

   // Decode the command
   always_comb begin
      slot_in       = '0;
      slot_in.valid = in_valid;
      slot_in.cmd   = command;
      num           = '0;
      dvs           = '0;
      case (command)
         fpa_pkg::CMD_ITOF:  slot_in.res = ai << FRACTION_BITS;
         fpa_pkg::CMD_FTOI:  slot_in.res =
                                fpa_pkg::sext32(64'($signed(operand_a) >>> FRACTION_BITS));
         fpa_pkg::CMD_ROUND: slot_in.res =
                                fpa_pkg::sext32(operand_a[63] ? rnd_neg : rnd_pos);
         fpa_pkg::CMD_ADDFF: slot_in.res = operand_a + operand_b;
         fpa_pkg::CMD_SUBFF: slot_in.res = operand_a - operand_b;
         fpa_pkg::CMD_ADDFI: slot_in.res = operand_a + (bi << FRACTION_BITS);
         fpa_pkg::CMD_SUBFI: slot_in.res = operand_a - (bi << FRACTION_BITS);
         fpa_pkg::CMD_MULFF: begin
            slot_in.ma = operand_a;
            slot_in.mb = operand_b;
         end
         fpa_pkg::CMD_MULFI: begin
            slot_in.ma = operand_a;
            slot_in.mb = bi;
         end
         fpa_pkg::CMD_DIVFF: begin
            num        = operand_a << FRACTION_BITS;
            dvs        = operand_b;
            slot_in.dz = (operand_b == '0);
         end
         fpa_pkg::CMD_DIVFI: begin
            num        = operand_a;
            dvs        = bi;
            slot_in.dz = (bi == '0);
         end
         default: slot_in.res = '0;
      endcase
      slot_in.neg = num[63] ^ dvs[63];
      slot_in.nq  = fpa_pkg::mag(num);
      slot_in.den = fpa_pkg::mag(dvs);
   end

   // Advance the stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= slot_in;
      end
   end

endmodule

### hdl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Two-stage 64x64 multiplier keeping the low 64 bits: 32x32 partial products
// in the first stage, sum and fraction shift in the second.
// ----------------------------------------------------------------------------
module fpa_mul #(
   parameter int FRACTION_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  fpa_pkg::pipe_type    in_slot,
   output fpa_pkg::pipe_type    out_ff
);

   fpa_pkg::pipe_type pp_ff;
   fpa_pkg::pipe_type pp_in;
   fpa_pkg::pipe_type sum_in;
   logic [63:0]       prod;

   // Form the partial products
   always_comb begin
      pp_in     = in_slot;
      pp_in.ma  = in_slot.ma[31:0] * in_slot.mb[31:0];
      pp_in.mb  = {32'(in_slot.ma[31:0] * in_slot.mb[63:32]),
                   32'(in_slot.ma[63:32] * in_slot.mb[31:0])};
   end

   // Sum the partial products and shift for the fixed-fixed product
   assign prod = pp_ff.ma + {pp_ff.mb[63:32] + pp_ff.mb[31:0], 32'd0};

   always_comb begin
      sum_in = pp_ff;
      if (pp_ff.cmd == fpa_pkg::CMD_MULFF) begin
         sum_in.res = 64'($signed(prod) >>> FRACTION_BITS);
      end else if (pp_ff.cmd == fpa_pkg::CMD_MULFI) begin
         sum_in.res = prod;
      end
   end

   // Advance both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         pp_ff  <= pp_in;
         out_ff <= sum_in;
      end
   end

endmodule

### hdl/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage
// One restoring division step: shift in a numerator bit, trial subtract,
// shift one quotient bit into the numerator/quotient register.
// ----------------------------------------------------------------------------
module fpa_div_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  fpa_pkg::pipe_type    in_slot,
   output fpa_pkg::pipe_type    out_ff
);

   fpa_pkg::pipe_type step_in;
   logic [64:0]       rem_sh;
   logic [64:0]       diff;

   assign rem_sh = {in_slot.rem, in_slot.nq[63]};
   assign diff   = rem_sh - {1'b0, in_slot.den};

   // Keep the difference when it does not go negative
   always_comb begin
      step_in = in_slot;
      if (!diff[64]) begin
         step_in.rem = diff[63:0];
         step_in.nq  = {in_slot.nq[62:0], 1'b1};
      end else begin
         step_in.rem = rem_sh[63:0];
         step_in.nq  = {in_slot.nq[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= step_in;
      end
   end

endmodule

### hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// Final stage: apply the quotient sign and select the division result.
// ----------------------------------------------------------------------------
module fpa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  fpa_pkg::pipe_type    in_slot,
   output fpa_pkg::pipe_type    out_ff
);

   fpa_pkg::pipe_type fin_in;
   logic              is_div;

   assign is_div = (in_slot.cmd == fpa_pkg::CMD_DIVFF) || (in_slot.cmd == fpa_pkg::CMD_DIVFI);

   // Division: zero divisor gives zero, otherwise restore the sign; else clear dz
   always_comb begin
      fin_in = in_slot;
      if (is_div) begin
         if (in_slot.dz) begin
            fin_in.res = '0;
         end else begin
            fin_in.res = in_slot.neg ? (64'(0) - in_slot.nq) : in_slot.nq;
         end
      end else begin
         fin_in.dz = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= fin_in;
      end
   end

endmodule

### hdl/fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Pipelined signed fixed-point ALU with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
// The core accepts one transaction per clock while req_stall is low and
// returns results in order. Every command, simple or not, travels the same
// 68-stage pipeline: one decode stage, two multiplier stages, 64 restoring
// divider stages (one quotient bit each) and one sign-fix stage, followed by
// the output register. The divider depth dominates the pipeline depth. A skid
// register behind the output register takes one result while rsp_stall is
// high; req_stall rises only once that register is full.
// A zero divisor returns 0 with rsp_divide_by_zero set.
// ----------------------------------------------------------------------------
module fixed_point_alu_core #(
   parameter int FRACTION_BITS = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [3:0]    req_command,
   input  logic [63:0]   req_operand_a,
   input  logic [63:0]   req_operand_b,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [63:0]   rsp_result,
   output logic          rsp_divide_by_zero
);

   localparam int DIV_STAGES = 64;

   fpa_pkg::pipe_type front_slot;
   fpa_pkg::pipe_type mul_slot;
   fpa_pkg::pipe_type div_slot [DIV_STAGES+1];
   fpa_pkg::pipe_type back_slot;

   logic        en;
   logic        rsp_valid_ff;
   logic [63:0] rsp_result_ff;
   logic        rsp_dz_ff;
   logic        skid_valid_ff;
   logic [63:0] skid_result_ff;
   logic        skid_dz_ff;

   // Hold the pipeline while the skid register is occupied
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .command   (req_command),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_ff    (front_slot)
   );

   fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_slot (front_slot),
      .out_ff  (mul_slot)
   );

   assign div_slot[0] = mul_slot;

   for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
      fpa_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_slot (div_slot[gi]),
         .out_ff  (div_slot[gi+1])
      );
   end

   fpa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_slot (div_slot[DIV_STAGES]),
      .out_ff  (back_slot)
   );

   // Load the output register from skid first, then from the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_result_ff <= skid_result_ff;
            rsp_dz_ff     <= skid_dz_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= back_slot.valid;
            rsp_result_ff <= back_slot.res;
            rsp_dz_ff     <= back_slot.dz;
         end
      end else if (en && back_slot.valid) begin
         skid_valid_ff  <= 1'b1;
         skid_result_ff <= back_slot.res;
         skid_dz_ff     <= back_slot.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   // A full skid register implies a pending output transaction
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds data with an empty output register");

   // A zero-divisor flag always comes with a zero result
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dz_ff) |-> (rsp_result_ff == '0))
      else $error("divide-by-zero result is not zero");

   // The skid register fills only while the output is stalled
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall && rsp_valid_ff))
      else $error("skid register filled without an output stall");

endmodule

### dv/fixed_point_alu_core_test.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_core_test
// Self-checking test of the fixed-point ALU: directed corner operands, then
// random commands and operands, checked in order against a local predictor.
// ----------------------------------------------------------------------------
module fixed_point_alu_core_test;

   localparam int FRAC = 14;
   localparam int RANDOM_COUNT = 900;

   typedef struct {
      logic [63:0] result;
      logic        dz;
   } alu_out_type;

   // Holds expected ALU results in order and compares them as they arrive.
   class alu_scoreboard;
      alu_out_type pending[$];
      int          errors;

      function automatic logic [63:0] low_sext(logic [63:0] x);
         return {{32{x[31]}}, x[31:0]};
      endfunction

      function automatic logic [63:0] quot(logic [63:0] n, logic [63:0] d);
         logic [63:0] mn, md, q;
         mn = n[63] ? -n : n;
         md = d[63] ? -d : d;
         q  = mn / md;
         return (n[63] != d[63]) ? -q : q;
      endfunction

      function automatic alu_out_type compute(logic [3:0] cmd, logic [63:0] a,
                                              logic [63:0] b);
         alu_out_type o;
         logic [63:0] bi, half, r, p;
         bi   = low_sext(b);
         half = 64'd1 << (FRAC - 1);
         o.result = '0;
         o.dz     = 1'b0;
         case (cmd)
            fpa_pkg::CMD_ITOF:  o.result = low_sext(a) << FRAC;
            fpa_pkg::CMD_FTOI:  o.result = low_sext($signed(a) >>> FRAC);
            fpa_pkg::CMD_ROUND: begin
               if (a[63]) begin
                  r = -a + half;
                  r = -($signed(r) >>> FRAC);
               end else begin
                  r = a + half;
                  r = $signed(r) >>> FRAC;
               end
               o.result = low_sext(r);
            end
            fpa_pkg::CMD_ADDFF: o.result = a + b;
            fpa_pkg::CMD_SUBFF: o.result = a - b;
            fpa_pkg::CMD_MULFF: begin
               p = a * b;
               o.result = $signed(p) >>> FRAC;
            end
            fpa_pkg::CMD_DIVFF: begin
               if (b == 0) o.dz = 1'b1;
               else o.result = quot(a << FRAC, b);
            end
            fpa_pkg::CMD_ADDFI: o.result = a + (bi << FRAC);
            fpa_pkg::CMD_SUBFI: o.result = a - (bi << FRAC);
            fpa_pkg::CMD_MULFI: o.result = a * bi;
            fpa_pkg::CMD_DIVFI: begin
               if (bi == 0) o.dz = 1'b1;
               else o.result = quot(a, bi);
            end
            default: ;
         endcase
         return o;
      endfunction

      function void note_request(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
         pending.push_back(compute(cmd, a, b));
      endfunction

      function void check_response(logic [63:0] res, logic dz);
         alu_out_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h dz %b", $time, res, dz);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.result !== res) begin
            $display("%0t: result expected %h actual %h", $time, e.result, res);
            errors++;
         end
         if (e.dz !== dz) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time, e.dz, dz);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_command;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result;
   logic        rsp_divide_by_zero;

   alu_scoreboard board;
   bit            quiet_phase;   // no idling on either side
   bit            hold_off_req;  // ask the receiver for a long stall
   bit            hold_off_done;

   fixed_point_alu_core #(.FRACTION_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result(rsp_result),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Offer one transaction, hold it until accepted, then note it.
   task automatic send_op(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
      while (!quiet_phase && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, a, b);
      @(negedge clock);
   endtask

   function automatic logic [63:0] pick_operand();
      case ($urandom_range(7))
         0: return {$urandom, $urandom};
         1: return {{32{1'b0}}, $urandom} & 64'h0000_0000_00FF_FFFF;
         2: return -({32'd0, $urandom} & 64'h0000_0000_00FF_FFFF);
         3: return {{32{1'b0}}, 32'(1) << $urandom_range(31)};
         4: return 64'($urandom_range(3));
         5: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(2));
         6: return {1'b1, 63'd0} | 64'($urandom_range(1));
         default: return {{32{1'b1}}, $urandom};
      endcase
   endfunction

   // Receiver: random stall, plus one long hold-off on request.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < 300; n++) @(negedge clock);
            hold_off_done = 1'b1;
         end
         rsp_stall <= (!quiet_phase && $urandom_range(99) < 7);
         @(negedge clock);
      end
   end

   // Check each accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_result, rsp_divide_by_zero);
   end

   initial begin
      logic [63:0] edge_vals[8];
      int          i, guard;
      board = new();
      edge_vals = '{64'h0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                    64'h8000_0000_0000_0000, 64'h0000_0000_8000_0000,
                    64'h0000_0000_0000_2000, 64'hFFFF_FFFF_FFFF_E000};
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      quiet_phase = 1'b0;
      hold_off_req = 1'b0;
      hold_off_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: every command on corner operands, zero divisors, overflow.
      for (i = 0; i < 16; i++)
         send_op(4'(i), edge_vals[i % 8], edge_vals[(i + 3) % 8]);
      send_op(fpa_pkg::CMD_DIVFF, 64'h1234, 64'h0);
      send_op(fpa_pkg::CMD_DIVFI, 64'h1234, 64'h5_0000_0000);
      send_op(fpa_pkg::CMD_DIVFI, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(fpa_pkg::CMD_DIVFF, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_op(fpa_pkg::CMD_ROUND, 64'h0000_0000_0000_6000, '0);
      send_op(fpa_pkg::CMD_ROUND, 64'hFFFF_FFFF_FFFF_A000, '0);
      send_op(fpa_pkg::CMD_ROUND, 64'h7FFF_FFFF_FFFF_FFFF, '0);
      send_op(fpa_pkg::CMD_MULFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);

      // Random: long hold-off first so the pipeline fills and stalls its input.
      hold_off_req = 1'b1;
      for (i = 0; i < RANDOM_COUNT; i++) begin
         quiet_phase = (i >= 400 && i < 550);
         send_op(($urandom_range(15) == 0) ? 4'(11 + $urandom_range(4))
                                           : 4'($urandom_range(10)),
                 pick_operand(), pick_operand());
      end
      req_valid <= 1'b0;

      // Drain, then allow the pipeline depth to pass.
      guard = 0;
      while (board.pending.size() != 0 && guard < 100_000) begin
         @(negedge clock);
         guard++;
      end
      repeat (150) @(negedge clock);
      if (board.pending.size() != 0) board.errors++;
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
